### rtl/pzt_pkg.sv
// Shared types and constants for the polygon zigzag triangulator.
// Used by pzt_corner_mem, pzt_seq and polygon_zigzag_triangulator.
`timescale 1ns / 1ps
`default_nettype none

package pzt_pkg;

    localparam int MAX_CORNERS = 64;
    localparam int INDEX_BITS  = 32;

    // Width of the vertex ports and of the stored corner value
    localparam int PORT_BITS  = 32;
    localparam int STORE_BITS = (INDEX_BITS < PORT_BITS) ? INDEX_BITS : PORT_BITS;

    // Store address and corner count (count must hold MAX_CORNERS itself)
    localparam int ADDR_BITS = (MAX_CORNERS > 1) ? $clog2(MAX_CORNERS) : 1;
    localparam int CNT_BITS  = $clog2(MAX_CORNERS + 1);

    typedef logic [STORE_BITS-1:0] corner_t;
    typedef logic [ADDR_BITS-1:0]  addr_t;
    typedef logic [CNT_BITS-1:0]   cnt_t;

    // Request from the sequencer to the corner store
    typedef struct packed {
        logic    we;
        addr_t   waddr;
        corner_t wdata;
        logic    re;
        addr_t   raddr;
    } mem_req_t;

    // One finished triangle handed to the output register
    typedef struct packed {
        corner_t a;
        corner_t b;
        corner_t c;
        logic    last;
        logic    dropped;
    } tri_t;

endpackage : pzt_pkg

`default_nettype wire

### rtl/polygon_zigzag_triangulator.sv
// Top level of the polygon zigzag triangulator: sequencer, corner store and
// output register. Depends on pzt_pkg, pzt_corner_mem and pzt_seq.
`timescale 1ns / 1ps
`default_nettype none

// Corners of a polygon arrive one transfer per cycle on the corner channel
// while corner_stall is low, with last_corner set on the final one; up to
// MAX_CORNERS (64) are kept and any beyond that are dropped, which sets
// corners_dropped on every triangle of that polygon. After the last corner
// the block emits n-2 triangles in zigzag strip order and takes no corner
// until the final triangle, marked by last_triangle, has entered the output
// register. Each triangle takes three reads through the single read port of
// the corner store and then a load of the output register, which waits while
// the output stalls. A polygon with fewer than three corners produces
// nothing and leaves the block ready for the next corner. The output
// register lets the next polygon load while the last triangle waits.
module polygon_zigzag_triangulator
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        corner_valid,
    output logic       corner_stall,
    input  wire [31:0] corner_vertex,
    input  wire        last_corner,
    output logic       tri_valid,
    input  wire        tri_stall,
    output logic [31:0] vertex_a,
    output logic [31:0] vertex_b,
    output logic [31:0] vertex_c,
    output logic       last_triangle,
    output logic       corners_dropped
);
    import pzt_pkg::*;

    mem_req_t req;
    corner_t  rdata;
    logic     out_free;
    logic     push;
    tri_t     tri_new;

    logic     valid_reg, valid_next;
    tri_t     tri_reg, tri_next;

    pzt_corner_mem u_mem
    (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    pzt_seq u_seq
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .corner_valid  (corner_valid),
        .corner_stall  (corner_stall),
        .corner_vertex (corner_vertex),
        .last_corner   (last_corner),
        .req           (req),
        .rdata         (rdata),
        .out_free      (out_free),
        .push          (push),
        .tri_out       (tri_new)
    );

    assign out_free = !valid_reg || !tri_stall;

    always_comb
    begin
        valid_next = valid_reg;
        tri_next   = tri_reg;
        if (push)
        begin
            valid_next = 1'b1;
            tri_next   = tri_new;
        end
        else if (!tri_stall)
        begin
            // Drop the triangle once its transfer completes
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tri_reg <= tri_next;
    end

    assign tri_valid       = valid_reg;
    assign vertex_a        = PORT_BITS'(tri_reg.a);
    assign vertex_b        = PORT_BITS'(tri_reg.b);
    assign vertex_c        = PORT_BITS'(tri_reg.c);
    assign last_triangle   = tri_reg.last;
    assign corners_dropped = tri_reg.dropped;

endmodule : polygon_zigzag_triangulator

`default_nettype wire

### rtl/pzt_corner_mem.sv
// Corner store: one write port, one read port with registered read data.
// Depends on pzt_pkg for widths and the request struct.
`timescale 1ns / 1ps
`default_nettype none

module pzt_corner_mem
(
    input  wire                    clk,
    input  wire pzt_pkg::mem_req_t req,
    output pzt_pkg::corner_t       rdata
);
    import pzt_pkg::*;

    corner_t mem [MAX_CORNERS];
    corner_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        // Read data holds while no read is issued
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : pzt_corner_mem

`default_nettype wire

### rtl/pzt_seq.sv
// Sequencer: buffers corners, then walks the strip order with one shared
// address adder and one store read in each read state. Depends on pzt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pzt_seq
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   corner_valid,
    output logic                  corner_stall,
    input  wire [31:0]            corner_vertex,
    input  wire                   last_corner,
    output pzt_pkg::mem_req_t     req,
    input  wire pzt_pkg::corner_t rdata,
    input  wire                   out_free,
    output logic                  push,
    output pzt_pkg::tri_t         tri_out
);
    import pzt_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,
        S_RD_A,
        S_RD_B,
        S_RD_C,
        S_PUSH
    } state_t;

    state_t  state_reg, state_next;
    cnt_t    count_reg, count_next;
    logic    ovf_reg, ovf_next;
    cnt_t    nm1_reg, nm1_next;
    cnt_t    nm2_reg, nm2_next;
    cnt_t    k_reg, k_next;
    corner_t a_reg, a_next;
    corner_t b_reg, b_next;

    logic    take;
    logic    room;
    cnt_t    n_new;
    cnt_t    h;
    cnt_t    add_x, add_y;
    logic    add_cin;
    cnt_t    add_sum;
    logic    is_last;

    assign corner_stall = (state_reg != S_LOAD);
    assign take         = corner_valid && !corner_stall;
    assign room         = (count_reg < cnt_t'(MAX_CORNERS));
    assign n_new        = room ? cnt_t'(count_reg + cnt_t'(1)) : count_reg;
    assign h            = k_reg >> 1;
    assign is_last      = (k_reg == cnt_t'(nm2_reg - cnt_t'(1)));

    // Shared address adder: h+1, h, (n-2)-h or (n-1)-h
    always_comb
    begin
        add_x   = h;
        add_y   = '0;
        add_cin = 1'b0;
        unique case (state_reg)
            S_RD_A:
            begin
                add_cin = 1'b1;
            end
            S_RD_B:
            begin
                if (k_reg[0])
                begin
                    add_x   = nm2_reg;
                    add_y   = ~h;
                    add_cin = 1'b1;
                end
            end
            S_RD_C:
            begin
                add_x   = nm1_reg;
                add_y   = ~h;
                add_cin = 1'b1;
            end
            default:
            begin
                add_x = h;
            end
        endcase
        add_sum = add_x + add_y + cnt_t'(add_cin);
    end

    always_comb
    begin
        req.we    = take && room;
        req.waddr = count_reg[ADDR_BITS-1:0];
        req.wdata = corner_vertex[STORE_BITS-1:0];
        req.re    = (state_reg == S_RD_A) || (state_reg == S_RD_B)
                    || (state_reg == S_RD_C);
        req.raddr = add_sum[ADDR_BITS-1:0];
    end

    assign push = (state_reg == S_PUSH) && out_free;

    always_comb
    begin
        tri_out.a       = a_reg;
        tri_out.b       = b_reg;
        tri_out.c       = rdata;
        tri_out.last    = is_last;
        tri_out.dropped = ovf_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        nm1_next   = nm1_reg;
        nm2_next   = nm2_reg;
        k_next     = k_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (take)
                begin
                    count_next = n_new;
                    ovf_next   = ovf_reg || !room;
                    if (last_corner)
                    begin
                        if (n_new >= cnt_t'(3))
                        begin
                            nm1_next   = cnt_t'(n_new - cnt_t'(1));
                            nm2_next   = cnt_t'(n_new - cnt_t'(2));
                            k_next     = '0;
                            state_next = S_RD_A;
                        end
                        else
                        begin
                            // Short polygon: drop it
                            count_next = '0;
                            ovf_next   = 1'b0;
                        end
                    end
                end
            end
            S_RD_A:
            begin
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                a_next     = rdata;
                state_next = S_RD_C;
            end
            S_RD_C:
            begin
                b_next     = rdata;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                // Hold until the output register can take the triangle
                if (out_free)
                begin
                    if (is_last)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next     = cnt_t'(k_reg + cnt_t'(1));
                        state_next = S_RD_A;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            nm1_reg   <= '0;
            nm2_reg   <= '0;
            k_reg     <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            nm1_reg   <= nm1_next;
            nm2_reg   <= nm2_next;
            k_reg     <= k_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
        end
    end

endmodule : pzt_seq

`default_nettype wire
